// ----- rtl/mdps_pkg.sv -----
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared types and constants of the minimal dependency prune store.
// ----------------------------------------------------------------------------
package mdps_pkg;

  localparam int unsigned MASK_W            = 32;
  localparam int unsigned CFG_W             = 6;
  localparam int unsigned CFG_RESET         = 32;
  localparam int unsigned APB_ADDR_W        = 3;
  localparam int unsigned APB_DATA_W        = 32;
  localparam int unsigned DEF_MAX_COLUMNS   = 32;
  localparam int unsigned DEF_SLOTS_PER_KEY = 8;

  // register index of columns_in_use
  localparam logic REG_COLUMNS_IN_USE = 1'b0;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic {
    MODE_SCAN = 1'b0,
    MODE_FIX  = 1'b1
  } rd_mode_e;

  typedef struct packed {
    logic     start;
    logic     clear;
    logic     rd_en;
    rd_mode_e mode;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic need_fix;
    logic is_query;
  } status_t;

endpackage

// ----- rtl/mdps_req_if.sv -----
// ----------------------------------------------------------------------------
// mdps_req_if
// Request channel: request type and column mask with valid/ready.
// ----------------------------------------------------------------------------
interface mdps_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [mdps_pkg::MASK_W-1:0]   column_mask;

  modport source (output valid, output req_type, output column_mask, input ready);
  modport sink   (input valid, input req_type, input column_mask, output ready);
endinterface

// ----- rtl/mdps_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mdps_rsp_if
// Response channel: prunable and overflow flags with valid/ready.
// ----------------------------------------------------------------------------
interface mdps_rsp_if;
  logic valid;
  logic ready;
  logic prunable;
  logic overflow;

  modport source (output valid, output prunable, output overflow, input ready);
  modport sink   (input valid, input prunable, input overflow, output ready);
endinterface

// ----- rtl/mdps_ctrl.sv -----
// ----------------------------------------------------------------------------
// mdps_ctrl
// Sequencer: clearing pass, slot scan, fix-up pass and response register.
// ----------------------------------------------------------------------------
module mdps_ctrl #(
  parameter int unsigned SLOTS_PER_KEY = mdps_pkg::DEF_SLOTS_PER_KEY,
  localparam int unsigned SLOT_W = (SLOTS_PER_KEY > 1) ? $clog2(SLOTS_PER_KEY) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output mdps_pkg::cmd_t      cmd_o,
  output logic [SLOT_W-1:0]   slot_addr_o,
  input  mdps_pkg::status_t   status_i
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SCAN_END = 7'b0001000,
    S_FIX      = 7'b0010000,
    S_FIX_END  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(SLOTS_PER_KEY - 1);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              cnt_last;

  assign cnt_last    = (cnt_q == LastSlot);
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign slot_addr_o = cnt_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    rsp_valid_d    = rsp_valid_q && !rsp_ready_i;
    cmd_o          = '0;
    cmd_o.mode     = mdps_pkg::MODE_SCAN;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        cnt_d       = cnt_last ? '0 : cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_last ? '0 : cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // need_fix already includes the last slot read out in this cycle
        state_d = status_i.need_fix ? S_FIX : S_DONE;
      end
      S_FIX: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.mode  = mdps_pkg::MODE_FIX;
        cnt_d       = cnt_last ? '0 : cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = S_FIX_END;
        end
      end
      S_FIX_END: begin
        cmd_o.mode = mdps_pkg::MODE_FIX;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  a_accept_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a scan");

  a_rsp_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("response raised outside of completion");

  a_no_fix_on_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX) |-> !status_i.is_query)
    else $error("fix-up pass entered for a query");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastSlot)
    else $error("slot counter out of range");

endmodule

// ----- rtl/mdps_datapath.sv -----
// ----------------------------------------------------------------------------
// mdps_datapath
// One slot memory per key column, scanned in parallel, with per-key flags.
// ----------------------------------------------------------------------------
module mdps_datapath #(
  parameter int unsigned MAX_COLUMNS   = mdps_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned SLOTS_PER_KEY = mdps_pkg::DEF_SLOTS_PER_KEY,
  localparam int unsigned SLOT_W = (SLOTS_PER_KEY > 1) ? $clog2(SLOTS_PER_KEY) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mdps_pkg::cmd_t                cmd_i,
  input  logic [SLOT_W-1:0]             slot_addr_i,
  input  logic [mdps_pkg::CFG_W-1:0]    cfg_columns_i,
  input  logic                          req_type_i,
  input  logic [mdps_pkg::MASK_W-1:0]   column_mask_i,
  output mdps_pkg::status_t             status_o,
  output logic                          prunable_o,
  output logic                          overflow_o
);

  localparam int unsigned MW       = mdps_pkg::MASK_W;
  localparam int unsigned CW       = mdps_pkg::CFG_W;
  // key columns beyond the mask width can never be present
  localparam int unsigned NUM_KEYS = (MAX_COLUMNS < MW) ? MAX_COLUMNS : MW;

  mdps_pkg::req_e     req_type_q;
  logic [MW-1:0]      mask_q;
  logic               rd_valid_q;
  mdps_pkg::rd_mode_e rd_mode_q;
  logic [SLOT_W-1:0]  rd_slot_q;
  logic               scan_eval, fix_eval;

  logic [NUM_KEYS-1:0] active;
  logic [NUM_KEYS-1:0] sub_q, sub_d;
  logic [NUM_KEYS-1:0] free_q, free_d;
  logic                prunable_q, overflow_q;

  assign scan_eval = rd_valid_q && (rd_mode_q == mdps_pkg::MODE_SCAN);
  assign fix_eval  = rd_valid_q && (rd_mode_q == mdps_pkg::MODE_FIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_mode_q <= cmd_i.mode;
    rd_slot_q <= slot_addr_i;
    if (cmd_i.start) begin
      req_type_q <= mdps_pkg::req_e'(req_type_i);
      mask_q     <= column_mask_i;
    end
    sub_q  <= sub_d;
    free_q <= free_d;
    if (cmd_i.load_out) begin
      prunable_q <= (req_type_q == mdps_pkg::REQ_QUERY) && |(active & sub_q);
      overflow_q <= (req_type_q == mdps_pkg::REQ_ADD) && |(active & ~sub_q & ~free_q);
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_bank
    logic [MW:0]       mem [SLOTS_PER_KEY];
    logic [MW:0]       rd_data_q;
    logic [MW:0]       wdata;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] free_slot_q;
    logic              we;
    logic              slot_vld;
    logic              is_sub;
    logic              is_super;

    assign active[k] = mask_q[k] && (CW'(k) < cfg_columns_i);
    assign slot_vld  = rd_data_q[MW];
    assign is_sub    = slot_vld && ((rd_data_q[MW-1:0] & ~mask_q) == '0);
    assign is_super  = slot_vld && ((mask_q & ~rd_data_q[MW-1:0]) == '0);

    // lowest slot that is empty or holds a superset that will be dropped
    always_comb begin
      sub_d[k]  = sub_q[k];
      free_d[k] = free_q[k];
      if (cmd_i.start) begin
        sub_d[k]  = 1'b0;
        free_d[k] = 1'b0;
      end else if (scan_eval) begin
        sub_d[k] = sub_q[k] | is_sub;
        if (!free_q[k] && (!slot_vld || is_super)) begin
          free_d[k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (scan_eval && !free_q[k] && (!slot_vld || is_super)) begin
        free_slot_q <= rd_slot_q;
      end
    end

    always_comb begin
      we    = 1'b0;
      wdata = {1'b0, rd_data_q[MW-1:0]};
      waddr = cmd_i.clear ? slot_addr_i : rd_slot_q;
      if (cmd_i.clear) begin
        we    = 1'b1;
        wdata = '0;
      end else if (fix_eval && active[k] && !sub_q[k] && free_q[k]) begin
        if (rd_slot_q == free_slot_q) begin
          we    = 1'b1;
          wdata = {1'b1, mask_q};
        end else if (is_super) begin
          we = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (cmd_i.rd_en) begin
        rd_data_q <= mem[slot_addr_i];
      end
    end
  end

  assign status_o.is_query = (req_type_q == mdps_pkg::REQ_QUERY);
  assign status_o.need_fix = (req_type_q == mdps_pkg::REQ_ADD) && |(active & ~sub_d & free_d);
  assign prunable_o        = prunable_q;
  assign overflow_o        = overflow_q;

endmodule

// ----- rtl/minimal_dependency_prune_store_unit.sv -----
// ----------------------------------------------------------------------------
// minimal_dependency_prune_store_unit
// Keeps minimal dependency masks per key column and answers prune queries.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i (req_type 0 adds column_mask, 1 queries it),
// one response per request leaves on rsp_o with prunable and overflow flags.
// Each key column owns its own slot memory and all keys are walked in
// parallel, one slot per cycle, in these steps:
//   query: a scan pass over all slots, then the response is registered
//   add:   the same scan pass; when something changes, a second pass
//          rewrites the slots before the response is registered
// One request is in flight at a time; the next one is taken as soon as the
// response sits in the output register, even if it has not been taken yet.
// If the receiver stalls with a response pending, the next result waits in
// the completion step until the output register is free.
// After reset a clearing pass empties every slot; no request is taken
// meanwhile, register writes are taken at any time.
// columns_in_use lives at APB address 0 and resets to 32.
module minimal_dependency_prune_store_unit #(
  parameter int unsigned MAX_COLUMNS   = mdps_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned SLOTS_PER_KEY = mdps_pkg::DEF_SLOTS_PER_KEY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mdps_req_if.sink                           req_i,
  mdps_rsp_if.source                         rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mdps_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mdps_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mdps_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned SLOT_W = (SLOTS_PER_KEY > 1) ? $clog2(SLOTS_PER_KEY) : 1;
  localparam int unsigned CW     = mdps_pkg::CFG_W;
  localparam int unsigned DW     = mdps_pkg::APB_DATA_W;

  logic [CW-1:0]      columns_q;
  logic               reg_sel;
  mdps_pkg::cmd_t     cmd;
  mdps_pkg::status_t  status;
  logic [SLOT_W-1:0]  slot_addr;

  assign reg_sel = (paddr[2] == mdps_pkg::REG_COLUMNS_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DW-CW){1'b0}}, columns_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= CW'(mdps_pkg::CFG_RESET);
    end else if (psel && penable && pwrite && reg_sel) begin
      columns_q <= pwdata[CW-1:0];
    end
  end

  mdps_ctrl #(
    .SLOTS_PER_KEY (SLOTS_PER_KEY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .slot_addr_o (slot_addr),
    .status_i    (status)
  );

  mdps_datapath #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .SLOTS_PER_KEY (SLOTS_PER_KEY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .slot_addr_i   (slot_addr),
    .cfg_columns_i (columns_q),
    .req_type_i    (req_i.req_type),
    .column_mask_i (req_i.column_mask),
    .status_o      (status),
    .prunable_o    (rsp_o.prunable),
    .overflow_o    (rsp_o.overflow)
  );

endmodule
